@@ hdl/planar_odometry_integrator_core_macros.svh @@
// Assertion macros for the odometry integrator.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define POI_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define POI_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define POI_ASSERT_IMP(label, clk, rst_n, a, c)
`define POI_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ hdl/poi_pkg.sv @@
package poi_pkg;
  localparam int TrigIterations = 16;
  localparam int IterW = $clog2(TrigIterations + 1);

  localparam logic [1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [1:0] CMD_ZERO     = 2'd1;
  localparam logic [1:0] CMD_SET      = 2'd2;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  // Arc tangent table in units of 2^-32 turn.
  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] v;
    begin
      case (i)
        5'd0: v = 34'sh20000000;  5'd1: v = 34'sh12E4051E;
        5'd2: v = 34'sh09FB385B;  5'd3: v = 34'sh051111D4;
        5'd4: v = 34'sh028B0D43;  5'd5: v = 34'sh0145D7E1;
        5'd6: v = 34'sh00A2F61E;  5'd7: v = 34'sh00517C55;
        5'd8: v = 34'sh0028BE53;  5'd9: v = 34'sh00145F2F;
        5'd10: v = 34'sh000A2F98; 5'd11: v = 34'sh000517CC;
        5'd12: v = 34'sh00028BE6; 5'd13: v = 34'sh000145F3;
        5'd14: v = 34'sh0000A2FA; 5'd15: v = 34'sh0000517D;
        5'd16: v = 34'sh000028BE; 5'd17: v = 34'sh0000145F;
        5'd18: v = 34'sh00000A30; 5'd19: v = 34'sh00000518;
        5'd20: v = 34'sh0000028C; 5'd21: v = 34'sh00000146;
        5'd22: v = 34'sh000000A3; 5'd23: v = 34'sh00000051;
        5'd24: v = 34'sh00000029; 5'd25: v = 34'sh00000014;
        5'd26: v = 34'sh0000000A; 5'd27: v = 34'sh00000005;
        5'd28: v = 34'sh00000003; default: v = 34'sh00000001;
      endcase
      return v;
    end
  endfunction

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture input item
    logic mul_turn;   // turn = rate * dt
    logic rot_start;  // start CORDIC on rotation angle
    logic cordic_step;
    logic mul_a;      // vx*c, vy*s
    logic mul_b;      // vx*s, vy*c
    logic sum_r;      // ry (rx is formed in the mul_b step)
    logic mul_dt;     // (r>>16)*dt
    logic accum;      // update pose
    logic q_start;    // start CORDIC on half heading
    logic emit;       // load output register
  } poi_cmd_t;

  typedef struct packed {
    logic cordic_done;
  } poi_sts_t;
endpackage

@@ hdl/poi_ctrl.sv @@
module poi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic              out_busy,
  input  poi_pkg::poi_sts_t sts,
  input  logic              have_prev,
  output poi_pkg::poi_cmd_t cmd
);
  import poi_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001, S_TURN = 11'b00000000010,
    S_ROT  = 11'b00000000100, S_ROTW = 11'b00000001000,
    S_MA   = 11'b00000010000, S_MB   = 11'b00000100000,
    S_SUM  = 11'b00001000000, S_MDT  = 11'b00010000000,
    S_ACC  = 11'b00100000000, S_QW   = 11'b01000000000,
    S_EMIT = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequencing of one input item; only a sample with a stored time leaves idle.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command == CMD_SAMPLE && have_prev) state_nxt = S_TURN;
        end
      end
      S_TURN: begin cmd.mul_turn = 1'b1; state_nxt = S_ROT; end
      S_ROT: begin cmd.rot_start = 1'b1; state_nxt = S_ROTW; end
      S_ROTW: begin
        cmd.cordic_step = 1'b1;
        if (sts.cordic_done) state_nxt = S_MA;
      end
      S_MA: begin cmd.mul_a = 1'b1; state_nxt = S_MB; end
      S_MB: begin cmd.mul_b = 1'b1; state_nxt = S_SUM; end
      S_SUM: begin cmd.sum_r = 1'b1; state_nxt = S_MDT; end
      S_MDT: begin cmd.mul_dt = 1'b1; state_nxt = S_ACC; end
      S_ACC: begin cmd.accum = 1'b1; state_nxt = S_QW; end
      S_QW: begin
        if (!sts.cordic_done) cmd.cordic_step = 1'b1;
        else if (!out_busy) state_nxt = S_EMIT;
      end
      S_EMIT: begin cmd.emit = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_ACC) cmd.q_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

@@ hdl/poi_dp.sv @@
module poi_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  poi_pkg::poi_cmd_t   cmd,
  output poi_pkg::poi_sts_t   sts,
  output logic                have_prev,
  input  logic                integration_mode,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_timestamp,
  input  logic signed [15:0]  in_vel_x,
  input  logic signed [15:0]  in_vel_y,
  input  logic signed [31:0]  in_turn_rate,
  input  logic signed [31:0]  in_set_x,
  input  logic signed [31:0]  in_set_y,
  input  logic [31:0]         in_set_heading,
  output logic [31:0]         r_x,
  output logic [31:0]         r_y,
  output logic [31:0]         r_heading,
  output logic [15:0]         r_qz,
  output logic [15:0]         r_qw,
  output logic [15:0]         r_vx,
  output logic [15:0]         r_vy,
  output logic [31:0]         r_rate,
  output logic [31:0]         r_stamp
);
  import poi_pkg::*;

  logic signed [31:0] acc_x_r, acc_y_r;
  logic [31:0] acc_h_r, prev_r, ts_r, dt_r;
  logic have_r;
  logic signed [15:0] vx_r, vy_r;
  logic signed [31:0] rate_r;
  logic signed [63:0] turn_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic flip_r;
  logic [IterW-1:0] it_r;
  logic signed [49:0] pa_r, pb_r;
  logic signed [50:0] rx_r, ry_r;
  logic signed [67:0] dx_r, dy_r;

  assign have_prev = have_r;
  assign sts.cordic_done = (it_r == IterW'(TrigIterations));

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Clamp a displacement so the following 34-bit add cannot wrap.
  function automatic logic signed [32:0] sat_dd(input logic signed [67:0] v);
    if (v > 68'sd4294967295) return 33'sh0FFFFFFFF;
    if (v < -68'sd4294967296) return 33'sh100000000;
    return v[32:0];
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] r;
    begin
      r = (35'(v) + 35'sd16384) >>> 15;
      if (r > 35'sd32767) return 16'h7FFF;
      if (r < -35'sd32768) return 16'h8000;
      return r[15:0];
    end
  endfunction

  logic [31:0] ang, ang_f;
  logic quad_flip;
  logic [31:0] half_turn, new_head;
  logic signed [33:0] sx, sy;

  always_comb begin
    half_turn = turn_r[40:9];
    new_head = acc_h_r + turn_r[39:8];
    ang = (cmd.q_start) ? {1'b0, new_head[31:1]}
        : (integration_mode ? acc_h_r + half_turn : acc_h_r);
    quad_flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    ang_f = quad_flip ? ang + 32'h80000000 : ang;
    sx = cx_r >>> it_r;
    sy = cy_r >>> it_r;
  end

  // Pose state, input capture, shared CORDIC and multiply steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0; acc_y_r <= '0; acc_h_r <= '0; prev_r <= '0; have_r <= 1'b0;
      it_r <= IterW'(TrigIterations);
    end else begin
      if (cmd.load) begin
        ts_r <= in_timestamp; vx_r <= in_vel_x; vy_r <= in_vel_y;
        rate_r <= in_turn_rate; dt_r <= in_timestamp - prev_r;
        if (in_command == CMD_ZERO) begin
          acc_x_r <= '0; acc_y_r <= '0; acc_h_r <= '0; have_r <= 1'b0;
        end else if (in_command == CMD_SET) begin
          acc_x_r <= in_set_x; acc_y_r <= in_set_y; acc_h_r <= in_set_heading;
          have_r <= 1'b0;
        end else if (in_command == CMD_SAMPLE && !have_r) begin
          prev_r <= in_timestamp; have_r <= 1'b1;
        end
      end
      if (cmd.mul_turn) turn_r <= rate_r * $signed({1'b0, dt_r});
      if (cmd.rot_start || cmd.q_start) begin
        cx_r <= CORDIC_START; cy_r <= '0; cz_r <= 34'($signed(ang_f));
        flip_r <= quad_flip; it_r <= '0;
      end else if (cmd.cordic_step && !sts.cordic_done) begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - sy; cy_r <= cy_r + sx;
          cz_r <= cz_r - atan_lut(5'(it_r));
        end else begin
          cx_r <= cx_r + sy; cy_r <= cy_r - sx;
          cz_r <= cz_r + atan_lut(5'(it_r));
        end
        it_r <= it_r + 1'b1;
      end
      if (cmd.mul_a) begin
        pa_r <= vx_r * (flip_r ? -cx_r : cx_r);
        pb_r <= vy_r * (flip_r ? -cy_r : cy_r);
      end
      if (cmd.mul_b) begin
        pa_r <= vx_r * (flip_r ? -cy_r : cy_r);
        pb_r <= vy_r * (flip_r ? -cx_r : cx_r);
        rx_r <= 51'(pa_r) - 51'(pb_r);
      end
      if (cmd.sum_r) ry_r <= 51'(pa_r) + 51'(pb_r);
      if (cmd.mul_dt) begin
        dx_r <= 68'(rx_r >>> 16) * $signed({36'd0, dt_r});
        dy_r <= 68'(ry_r >>> 16) * $signed({36'd0, dt_r});
      end
      if (cmd.accum) begin
        acc_x_r <= sat32(34'(acc_x_r) + 34'(sat_dd(dx_r >>> 22)));
        acc_y_r <= sat32(34'(acc_y_r) + 34'(sat_dd(dy_r >>> 22)));
        acc_h_r <= new_head;
        prev_r <= ts_r;
      end
      if (cmd.emit) begin
        r_x <= acc_x_r; r_y <= acc_y_r; r_heading <= acc_h_r;
        r_qz <= to_q15(flip_r ? -cy_r : cy_r);
        r_qw <= to_q15(flip_r ? -cx_r : cx_r);
        r_vx <= vx_r; r_vy <= vy_r; r_rate <= rate_r; r_stamp <= ts_r;
      end
    end
  end
endmodule

@@ hdl/planar_odometry_integrator_core.sv @@
// Planar dead-reckoning pose integrator.
// The input channel (in_valid/in_ready) takes one command per transfer:
// a velocity sample, a reset of the pose to zero, or a reset to set values.
// Reset commands and the first sample after a reset take one cycle and
// produce no result. A later sample integrates over the timestamp difference
// and produces one result on the out_ channel with pose, yaw quaternion and
// echoed velocities.
// A sample uses the single shared CORDIC unit twice, once for the rotation
// and once for the quaternion. One item is in work at a time. The result
// sits in an output register; the next item is accepted while it waits, and
// only a second result waits for the receiver to take the first.
// cfg_we writes integration_mode (0 Euler, 1 midpoint); the user must write
// it only while idle, and the block itself does not enforce this.
// Synchronous reset clears the pose, the stored time and the mode.
`include "planar_odometry_integrator_core_macros.svh"
module planar_odometry_integrator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [31:0]        in_timestamp,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [31:0] in_turn_rate,
  input  logic signed [31:0] in_set_x,
  input  logic signed [31:0] in_set_y,
  input  logic [31:0]        in_set_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_echo_vel_x,
  output logic signed [15:0] out_echo_vel_y,
  output logic signed [31:0] out_echo_turn_rate,
  output logic [31:0]        out_stamp
);
  import poi_pkg::*;

  poi_cmd_t cmd;
  poi_sts_t sts;
  logic have_prev, mode_r, out_valid_r;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end
  assign out_valid = out_valid_r;

  poi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_command,
    .out_busy(out_valid_r && !out_ready), .sts, .have_prev, .cmd
  );

  poi_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .have_prev, .integration_mode(mode_r),
    .in_command, .in_timestamp, .in_vel_x, .in_vel_y, .in_turn_rate,
    .in_set_x, .in_set_y, .in_set_heading,
    .r_x(out_pos_x), .r_y(out_pos_y), .r_heading(out_heading),
    .r_qz(out_quat_z), .r_qw(out_quat_w), .r_vx(out_echo_vel_x),
    .r_vy(out_echo_vel_y), .r_rate(out_echo_turn_rate), .r_stamp(out_stamp)
  );

  `POI_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `POI_ASSERT_NXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid)
  `POI_ASSERT_IMP(a_no_accept_busy, clk, rst_n, cmd.cordic_step, !in_ready)
endmodule
